[rtl/core/nrf_pkg.sv]
package nrf_pkg;

  localparam int CACHE_DEPTH = 256;
  localparam int NONCE_BYTES = 16;

  localparam int WORD_W = 64;
  localparam int ADDR_W = $clog2(CACHE_DEPTH);
  localparam int CNT_W  = $clog2(CACHE_DEPTH + 1);

  localparam logic [WORD_W-1:0] NONCE_MASK_LO =
    (NONCE_BYTES >= 8) ? {WORD_W{1'b1}} :
    ((WORD_W'(1) << (8 * NONCE_BYTES)) - WORD_W'(1));

  localparam logic [WORD_W-1:0] NONCE_MASK_HI =
    (NONCE_BYTES <= 8)  ? {WORD_W{1'b0}} :
    (NONCE_BYTES >= 16) ? {WORD_W{1'b1}} :
    ((WORD_W'(1) << (8 * (NONCE_BYTES - 8))) - WORD_W'(1));

  typedef struct packed {
    logic [WORD_W-1:0] nonce_lo;
    logic [WORD_W-1:0] nonce_hi;
    logic [WORD_W-1:0] id_lo;
    logic [WORD_W-1:0] id_hi;
  } tag_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    tag_t              wr_data;
  } ram_req_t;

endpackage

[rtl/core/nrf_tag_ram.sv]
module nrf_tag_ram (
  input  logic              clk,
  input  nrf_pkg::ram_req_t req,
  output nrf_pkg::tag_t     rd_data
);

  nrf_pkg::tag_t mem [nrf_pkg::CACHE_DEPTH];
  nrf_pkg::tag_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/nrf_ctrl.sv]
module nrf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nrf_pkg::tag_t     in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_novel,
  output nrf_pkg::ram_req_t ram_req,
  input  nrf_pkg::tag_t     rd_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_RESULT} state_t;

  state_t                      state_r, state_nxt;
  nrf_pkg::tag_t               tag_r, tag_nxt;
  logic [nrf_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic [nrf_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [nrf_pkg::ADDR_W-1:0]  head_r, head_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic                        res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_novel_r, out_novel_nxt;
  logic                        rd_en;
  logic                        hit;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_novel = out_novel_r;

  assign rd_en = (state_r == ST_SCAN) && (idx_r < fill_r);
  assign hit   = rd_pend_r && (rd_data == tag_r);

  always_comb begin
    ram_req         = '0;
    ram_req.rd_en   = rd_en;
    ram_req.rd_addr = idx_r[nrf_pkg::ADDR_W-1:0];
    ram_req.wr_en   = (state_r == ST_WRITE);
    ram_req.wr_addr = head_r;
    ram_req.wr_data = tag_r;
  end

  always_comb begin
    state_nxt     = state_r;
    tag_nxt       = tag_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    rd_pend_nxt   = 1'b0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_novel_nxt = out_novel_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tag_nxt          = in_tag;
          tag_nxt.nonce_hi = in_tag.nonce_hi & nrf_pkg::NONCE_MASK_HI;
          tag_nxt.nonce_lo = in_tag.nonce_lo & nrf_pkg::NONCE_MASK_LO;
          idx_nxt          = '0;
          state_nxt        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_nxt   = 1'b0;
          state_nxt = ST_RESULT;
        end else if (!rd_en && !rd_pend_r) begin
          state_nxt = ST_WRITE;
        end else begin
          rd_pend_nxt = rd_en;
          if (rd_en) begin
            idx_nxt = idx_r + nrf_pkg::CNT_W'(1);
          end
        end
      end
      ST_WRITE: begin
        if (head_r == nrf_pkg::ADDR_W'(nrf_pkg::CACHE_DEPTH - 1)) begin
          head_nxt = '0;
        end else begin
          head_nxt = head_r + nrf_pkg::ADDR_W'(1);
        end
        if (fill_r != nrf_pkg::CNT_W'(nrf_pkg::CACHE_DEPTH)) begin
          fill_nxt = fill_r + nrf_pkg::CNT_W'(1);
        end
        res_nxt   = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_novel_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    tag_r       <= tag_nxt;
    idx_r       <= idx_nxt;
    res_r       <= res_nxt;
    out_novel_r <= out_novel_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      head_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/nonce_replay_filter.sv]
// Channel   Direction  Payload
// in_*      slave      tdata: id_hi, id_lo, nonce_hi, nonce_lo (64 bits each)
// out_*     master     tdata: novel (bit 0, zero padded to 8 bits)
//
// A transaction compares against up to fill_count cached tags, at most CACHE_DEPTH,
// one compare per cycle over the single tag RAM read port, before its result is loaded.
// A new transaction is accepted only after the previous result is loaded in the
// output register; that register holds while out_tready is low.
// Reset empties the cache at once (fill count and write head to zero).
module nonce_replay_filter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // id_hi, id_lo, nonce_hi, nonce_lo
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // novel, zero padding
);

  nrf_pkg::tag_t     in_tag;
  nrf_pkg::tag_t     rd_data;
  nrf_pkg::ram_req_t ram_req;
  logic              novel;

  assign in_tag.id_hi    = in_tdata[63:0];
  assign in_tag.id_lo    = in_tdata[127:64];
  assign in_tag.nonce_hi = in_tdata[191:128];
  assign in_tag.nonce_lo = in_tdata[255:192];

  assign out_tdata = {7'd0, novel};

  nrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_tag    (in_tag),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_novel (novel),
    .ram_req   (ram_req),
    .rd_data   (rd_data)
  );

  nrf_tag_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

endmodule

[bench/testbench.sv]
module testbench;

  localparam int RANDOM_TAGS = 1350;
  localparam int HISTORY_MAX = 320;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata   = '0;   // id_hi, id_lo, nonce_hi, nonce_lo
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;         // novel, zero padding

  nonce_replay_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nrf_pkg::tag_t pending_tags[$];
  nrf_pkg::tag_t sent_history[$];
  bit            novel_expected[$];

  nrf_pkg::tag_t              cache_tags[nrf_pkg::CACHE_DEPTH];
  logic [nrf_pkg::ADDR_W-1:0] cache_head = '0;
  logic [nrf_pkg::CNT_W-1:0]  cache_fill = '0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int burst_left     = 1;
  int gap_left       = 0;
  int hold_left      = 0;
  int unsigned rx_cycle = 0;
  logic [15:0] rx_lfsr  = 16'hACE1;

  // Search newest to oldest; record on a miss.
  function automatic bit register_tag(nrf_pkg::tag_t t);
    int slot;
    t.nonce_hi &= nrf_pkg::NONCE_MASK_HI;
    t.nonce_lo &= nrf_pkg::NONCE_MASK_LO;
    for (int i = 0; i < int'(cache_fill); i++) begin
      slot = (int'(cache_head) + nrf_pkg::CACHE_DEPTH - 1 - i) % nrf_pkg::CACHE_DEPTH;
      if (cache_tags[slot] == t) return 1'b0;
    end
    cache_tags[cache_head] = t;
    cache_head = nrf_pkg::ADDR_W'((int'(cache_head) + 1) % nrf_pkg::CACHE_DEPTH);
    if (int'(cache_fill) < nrf_pkg::CACHE_DEPTH) cache_fill = cache_fill + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic nrf_pkg::tag_t random_tag();
    nrf_pkg::tag_t t;
    t.id_hi    = random_word();
    t.id_lo    = random_word();
    t.nonce_hi = random_word();
    t.nonce_lo = random_word();
    return t;
  endfunction

  function automatic nrf_pkg::tag_t pick_recent();
    int span;
    int n;
    n = sent_history.size();
    if ($urandom_range(0, 2) != 0) begin
      span = (n < 40) ? n : 40;
      return sent_history[n - 1 - $urandom_range(0, span - 1)];
    end
    return sent_history[$urandom_range(0, n - 1)];
  endfunction

  task automatic queue_tag(nrf_pkg::tag_t t);
    pending_tags.push_back(t);
    sent_history.push_back(t);
    if (sent_history.size() > HISTORY_MAX) void'(sent_history.pop_front());
  endtask

  // tag_t layout matches tdata: id_hi in the low bits.
  always @(posedge clk) begin : driver
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        novel_expected.push_back(register_tag(nrf_pkg::tag_t'(in_tdata)));
        nxt_valid = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            9:       gap_left = $urandom_range(20, 300);
            default: gap_left = $urandom_range(1, 12);
          endcase
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_tags.size() > 0) begin
          in_tdata  <= pending_tags.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  always @(posedge clk) begin : monitor
    logic [7:0] want;
    logic       rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      rx_lfsr = {rx_lfsr[14:0], rx_lfsr[15] ^ rx_lfsr[13] ^ rx_lfsr[12] ^ rx_lfsr[10]};
      if (out_tvalid && out_tready) begin
        if (novel_expected.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = {7'b0, novel_expected.pop_front()};
          if (out_tdata !== want) begin
            $display("%0t: novel mismatch, expected %h, got %h", $time, want, out_tdata);
            mismatch_count++;
          end
        end
        results_seen++;
        if (results_seen == 400) hold_left = 900;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_cycle[10:9])
          2'd0:    rdy = 1'b1;
          2'd1:    rdy = (rx_lfsr[1:0] != 2'b00);
          2'd2:    rdy = (rx_lfsr[1:0] == 2'b00);
          default: rdy = rx_lfsr[2];
        endcase
      end
      out_tready <= rdy;
    end
  end

  initial begin : stimulus
    nrf_pkg::tag_t t;
    nrf_pkg::tag_t zero_tag;
    nrf_pkg::tag_t ones_tag;
    zero_tag = '0;
    ones_tag = '1;

    queue_tag(zero_tag);
    queue_tag(zero_tag);
    queue_tag(ones_tag);
    queue_tag(ones_tag);
    for (int f = 0; f < 4; f++) begin
      t = zero_tag;
      case (f)
        0: t.id_hi    = '1;
        1: t.id_lo    = '1;
        2: t.nonce_hi = '1;
        default: t.nonce_lo = '1;
      endcase
      queue_tag(t);
    end
    for (int f = 0; f < 4; f++) begin
      t = zero_tag;
      case (f)
        0: t.id_hi    = 64'd1;
        1: t.id_lo    = 64'd1;
        2: t.nonce_hi = 64'h8000_0000_0000_0000;
        default: t.nonce_lo = 64'd1;
      endcase
      queue_tag(t);
    end
    queue_tag(zero_tag);
    t = ones_tag;
    t.nonce_lo[0] = 1'b0;
    queue_tag(t);
    t = ones_tag;
    t.id_hi[63] = 1'b0;
    queue_tag(t);
    t = zero_tag;
    t.id_lo = '1;
    queue_tag(t);
    queue_tag(t);

    for (int k = 0; k < RANDOM_TAGS; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: t = random_tag();
        9, 10, 11, 12, 13, 14, 15: t = pick_recent();
        default: begin
          t = pick_recent();
          case ($urandom_range(0, 3))
            0: t.id_hi    ^= 64'd1 << $urandom_range(0, 63);
            1: t.id_lo    ^= 64'd1 << $urandom_range(0, 63);
            2: t.nonce_hi ^= 64'd1 << $urandom_range(0, 63);
            default: t.nonce_lo ^= 64'd1 << $urandom_range(0, 63);
          endcase
        end
      endcase
      queue_tag(t);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_tags.size() != 0 || in_tvalid || novel_expected.size() != 0)
      @(negedge clk);
    repeat (nrf_pkg::CACHE_DEPTH + 16) @(posedge clk);

    if (mismatch_count == 0 && novel_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
